/* src/ffsa_pkg.sv */
package ffsa_pkg;

	localparam int ACC_W      = 48;
	localparam int CELL_FLD_W = 10;
	localparam int VAR_FLD_W  = 3;
	localparam int WORD_W     = 32;
	localparam int NV_W       = 4;
	localparam int DOM_W      = 11;
	localparam int DIVIDEND_W = 64;
	localparam int DIVISOR_W  = 32;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARS     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_CELLS = 1'd1;
	localparam logic [NV_W-1:0]      NUM_VARS_RST     = 4'd5;
	localparam logic [DOM_W-1:0]     DOMAIN_RST       = 11'd1024;

	// input actions
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_FACE  = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// queued operations
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_FACE  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam int QUEUE_DEPTH = 2;

	localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

	typedef struct packed {
		logic [1:0]            op;
		logic [CELL_FLD_W-1:0] left_cell;
		logic [CELL_FLD_W-1:0] right_cell;
		logic [VAR_FLD_W-1:0]  var_idx;
		logic [WORD_W-1:0]     flux;
		logic [WORD_W-1:0]     area;
		logic [WORD_W-1:0]     volume;
		logic                  domain;
		logic [NV_W-1:0]       nvars;
	} ffsa_entry_t;

endpackage

/* src/ffsa_if.sv */
interface ffsa_in_if;
	logic                valid;
	logic                ready;
	logic [1:0]          action;
	logic [9:0]          left_cell;
	logic [9:0]          right_cell;
	logic [2:0]          var_index;
	logic signed [31:0]  flux;
	logic [31:0]         area;
	logic [31:0]         volume;

	modport source(output valid, action, left_cell, right_cell, var_index, flux, area, volume,
		input ready);
	modport sink(input valid, action, left_cell, right_cell, var_index, flux, area, volume,
		output ready);
endinterface

interface ffsa_out_if;
	logic                valid;
	logic                ready;
	logic [2:0]          out_var;
	logic signed [47:0]  derivative;
	logic                div_error;
	logic                last;

	modport source(output valid, out_var, derivative, div_error, last, input ready);
	modport sink(input valid, out_var, derivative, div_error, last, output ready);
endinterface

/* src/ffsa_front.sv */
module ffsa_front import ffsa_pkg::*; #(
	parameter int MAX_CELLS = 1024,
	parameter int MAX_VARS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ffsa_in_if.sink               item,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  init_done,
	input  logic                  q_full,
	output logic                  q_push,
	output ffsa_entry_t           q_din
);

	localparam int VLIM = (MAX_VARS < 8) ? MAX_VARS : 8;

	logic [NV_W-1:0]  num_vars_q;
	logic [DOM_W-1:0] domain_q;
	logic [NV_W-1:0]  nv_eff;
	logic             keep;
	logic             cell_l_ok, cell_r_ok;
	ffsa_entry_t      ent;
	ffsa_entry_t      ent_s1;
	logic             valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vars_q <= NUM_VARS_RST;
			domain_q   <= DOMAIN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_NUM_VARS:     num_vars_q <= cfg_wdata[NV_W-1:0];
				CFG_DOMAIN_CELLS: domain_q   <= cfg_wdata[DOM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (num_vars_q == '0)
			nv_eff = NV_W'(1);
		else if (32'(num_vars_q) > VLIM)
			nv_eff = NV_W'(VLIM);
		else
			nv_eff = num_vars_q;
	end

	assign cell_l_ok = 32'(item.left_cell) < MAX_CELLS;
	assign cell_r_ok = 32'(item.right_cell) < MAX_CELLS;

	always_comb begin
		ent.left_cell  = item.left_cell;
		ent.right_cell = item.right_cell;
		ent.var_idx    = item.var_index;
		ent.flux       = item.flux;
		ent.area       = item.area;
		ent.volume     = item.volume;
		ent.domain     = {1'b0, item.left_cell} < domain_q;
		ent.nvars      = nv_eff;
		case (item.action)
			ACT_CLEAR: begin
				ent.op = OP_CLEAR;
				keep   = 1'b1;
			end
			ACT_FACE: begin
				ent.op = OP_FACE;
				keep   = cell_l_ok && cell_r_ok && ({1'b0, item.var_index} < nv_eff);
			end
			ACT_READ: begin
				ent.op = OP_READ;
				keep   = cell_l_ok;
			end
			default: begin
				ent.op = OP_CLEAR;
				keep   = 1'b0;
			end
		endcase
	end

	assign item.ready = init_done && (!valid_s1 || !q_full);
	assign q_push     = valid_s1 && !q_full;
	assign q_din      = ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (item.valid && item.ready)
			valid_s1 <= keep;
		else if (q_push)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready)
			ent_s1 <= ent;
	end

endmodule

/* src/ffsa_queue.sv */
module ffsa_queue import ffsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  ffsa_entry_t din,
	output logic        full,
	input  logic        pop,
	output ffsa_entry_t dout,
	output logic        empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	ffsa_entry_t        slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= din;
	end

endmodule

/* src/ffsa_div.sv */
module ffsa_div import ffsa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W);

	logic                  busy_q, done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] dvd_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVISOR_W:0]    rem_sh;
	logic                  fits;

	// restoring shift-subtract, one quotient bit per cycle
	assign rem_sh = {rem_q, dvd_q[DIVIDEND_W-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	assign done     = done_q;
	assign quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? DIVISOR_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[DIVISOR_W-1:0];
		end
	end

endmodule

/* src/ffsa_back.sv */
module ffsa_back import ffsa_pkg::*; #(
	parameter int MAX_CELLS = 1024,
	parameter int MAX_VARS  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  ffsa_entry_t q_head,
	output logic        q_pop,
	output logic        init_done,
	ffsa_out_if.source  result
);

	localparam int CELL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int VAR_W  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
	localparam int ADDR_W = CELL_W + VAR_W;
	localparam int DEPTH  = 1 << ADDR_W;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_F0    = 4'd2;
	localparam logic [3:0] ST_F1    = 4'd3;
	localparam logic [3:0] ST_F2    = 4'd4;
	localparam logic [3:0] ST_F3    = 4'd5;
	localparam logic [3:0] ST_R0    = 4'd6;
	localparam logic [3:0] ST_R1    = 4'd7;
	localparam logic [3:0] ST_RDIV  = 4'd8;
	localparam logic [3:0] ST_RPUT  = 4'd9;

	function automatic logic signed [ACC_W-1:0] clamp50(input logic signed [ACC_W+1:0] v);
		if (v > (ACC_W+2)'(ACC_MAX))
			return ACC_MAX;
		else if (v < (ACC_W+2)'(ACC_MIN))
			return ACC_MIN;
		else
			return v[ACC_W-1:0];
	endfunction

	logic [3:0]         state_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [2:0]         j_q;
	logic               init_done_q;
	ffsa_entry_t        cur_q;

	logic signed [ACC_W-1:0] mem [DEPTH];
	logic signed [ACC_W-1:0] rd_a_q, rd_b_q;
	logic                    mem_we, mem_re;
	logic [ADDR_W-1:0]       mem_wa;
	logic signed [ACC_W-1:0] mem_wd;

	logic [2*WORD_W-1:0]     mul_q;
	logic signed [ACC_W:0]   prod_q;
	logic signed [ACC_W-1:0] base_q;
	logic signed [ACC_W-1:0] val_q;
	logic                    err_q;
	logic                    sign_q;

	logic                    res_valid_q;
	logic [2:0]              res_var_q;
	logic signed [ACC_W-1:0] res_der_q;
	logic                    res_err_q, res_last_q;

	logic [ADDR_W-1:0]       addr_l, addr_r, addr_c;
	logic                    last_var, can_emit, finish, take;
	logic [3:0]              disp_state;
	logic [WORD_W-1:0]       fmag;
	logic [2*WORD_W-1:0]     rnd;
	logic [ACC_W-1:0]        pmag;
	logic signed [ACC_W-1:0] new_l, new_r;
	logic signed [ACC_W-1:0] acc;
	logic                    acc_neg_res;
	logic [ACC_W-1:0]        amag;
	logic                    div_start, div_done;
	logic [DIVIDEND_W-1:0]   quot;
	logic signed [ACC_W-1:0] quot_sat;

	assign addr_l = {CELL_W'(cur_q.left_cell), VAR_W'(cur_q.var_idx)};
	assign addr_r = {CELL_W'(cur_q.right_cell), VAR_W'(cur_q.var_idx)};
	assign addr_c = {CELL_W'(cur_q.left_cell), VAR_W'(j_q)};

	assign last_var = {1'b0, j_q} == (cur_q.nvars - 1'b1);
	assign can_emit = !res_valid_q || result.ready;
	assign finish   = (state_q == ST_CLEAR && clr_q == ADDR_W'(DEPTH - 1))
	                || state_q == ST_F3
	                || (state_q == ST_RPUT && can_emit && last_var);
	assign take     = (state_q == ST_IDLE || finish) && !q_empty;
	assign q_pop    = take;
	assign init_done = init_done_q;

	always_comb begin
		case (q_head.op)
			OP_CLEAR: disp_state = ST_CLEAR;
			OP_FACE:  disp_state = ST_F0;
			OP_READ:  disp_state = ST_R0;
			default:  disp_state = ST_IDLE;
		endcase
	end

	// face arithmetic: rounded magnitude product, then saturating updates
	assign fmag  = cur_q.flux[WORD_W-1] ? (~cur_q.flux + 1'b1) : cur_q.flux;
	assign rnd   = mul_q + (2*WORD_W)'(32'h8000);
	assign pmag  = rnd[ACC_W+15:16];
	assign new_l = clamp50((ACC_W+2)'(rd_a_q) + (ACC_W+2)'(prod_q));
	assign new_r = clamp50((ACC_W+2)'(base_q) - (ACC_W+2)'(prod_q));

	// readout arithmetic
	assign acc         = rd_a_q;
	assign acc_neg_res = acc > 0;
	assign amag        = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
	assign div_start   = state_q == ST_R1 && cur_q.domain && cur_q.volume != '0;

	always_comb begin
		if (sign_q)
			quot_sat = (quot >= DIVIDEND_W'(64'h8000_0000_0000)) ? ACC_MIN
			         : -$signed(quot[ACC_W-1:0]);
		else
			quot_sat = (quot > DIVIDEND_W'(64'h7FFF_FFFF_FFFF)) ? ACC_MAX
			         : $signed(quot[ACC_W-1:0]);
	end

	ffsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({amag, 16'h0000}),
		.divisor  (cur_q.volume),
		.done     (div_done),
		.quotient (quot)
	);

	// accumulator store port mux
	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = '0;
		mem_re = 1'b0;
		case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_F0:    mem_re = 1'b1;
			ST_F2: begin
				mem_we = 1'b1;
				mem_wa = addr_l;
				mem_wd = new_l;
			end
			ST_F3: begin
				mem_we = 1'b1;
				mem_wa = addr_r;
				mem_wd = new_r;
			end
			ST_R0:    mem_re = 1'b1;
			ST_RPUT: begin
				mem_we = can_emit && cur_q.domain;
				mem_wa = addr_c;
				mem_wd = val_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re) begin
			rd_a_q <= mem[(state_q == ST_F0) ? addr_l : addr_c];
			rd_b_q <= mem[addr_r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			j_q         <= '0;
			init_done_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1))
						init_done_q <= 1'b1;
				end
				ST_F0:   state_q <= ST_F1;
				ST_F1:   state_q <= ST_F2;
				ST_F2:   state_q <= ST_F3;
				ST_R0:   state_q <= ST_R1;
				ST_R1:   state_q <= div_start ? ST_RDIV : ST_RPUT;
				ST_RDIV: if (div_done) state_q <= ST_RPUT;
				ST_RPUT: if (can_emit && !last_var) begin
					j_q     <= j_q + 1'b1;
					state_q <= ST_R0;
				end
				default: ;
			endcase
			if (take) begin
				state_q <= disp_state;
				clr_q   <= '0;
				j_q     <= '0;
			end else if (finish) begin
				state_q <= ST_IDLE;
			end

			if (state_q == ST_RPUT && can_emit)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			cur_q <= q_head;
		case (state_q)
			ST_F0: mul_q  <= fmag * cur_q.area;
			ST_F1: prod_q <= cur_q.flux[WORD_W-1] ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
			ST_F2: base_q <= (cur_q.left_cell == cur_q.right_cell) ? new_l : rd_b_q;
			ST_R1: begin
				sign_q <= acc_neg_res;
				if (!cur_q.domain) begin
					val_q <= acc;
					err_q <= 1'b0;
				end else if (cur_q.volume == '0) begin
					err_q <= 1'b1;
					val_q <= (acc == 0) ? '0 : (acc_neg_res ? ACC_MIN : ACC_MAX);
				end else begin
					err_q <= 1'b0;
				end
			end
			ST_RDIV: if (div_done) val_q <= quot_sat;
			ST_RPUT: if (can_emit) begin
				res_var_q  <= j_q;
				res_der_q  <= val_q;
				res_err_q  <= err_q;
				res_last_q <= last_var;
			end
			default: ;
		endcase
	end

	assign result.valid      = res_valid_q;
	assign result.out_var    = res_var_q;
	assign result.derivative = res_der_q;
	assign result.div_error  = res_err_q;
	assign result.last       = res_last_q;

endmodule

/* src/face_flux_scatter_accumulator_top.sv */
// Face update: back-end states F0 to F3, one read-modify-write pair on the accumulator RAM.
// Readout: per variable, states R0, R1, RPUT for boundary cells or zero volume; domain
// cells add RDIV, waiting on the 1-bit-per-cycle divider (64 shifts, then a done strobe);
// plus the front stage register and the queue ahead of the back end.
// Clear: one RAM entry per cycle over all 2**(CELL_W + VAR_W) entries (8192 default).
// Reset: async active low; the same clearing pass runs after reset, input not ready till done.
module face_flux_scatter_accumulator_top import ffsa_pkg::*; #(
	parameter int MAX_CELLS = 1024,
	parameter int MAX_VARS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ffsa_in_if.sink               item,
	ffsa_out_if.source            result,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// front: config registers, classification, range checks, one stage register
	// queue: decouples front acceptance from the back sequencer
	// back: accumulator RAM, face RMW sequencer, readout with divider, output register

	logic        q_push, q_full, q_pop, q_empty;
	logic        init_done;
	ffsa_entry_t q_din, q_head;

	ffsa_front #(
		.MAX_CELLS (MAX_CELLS),
		.MAX_VARS  (MAX_VARS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.init_done (init_done),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_din     (q_din)
	);

	ffsa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_head),
		.empty  (q_empty)
	);

	// each result transaction leaves from the back end's output register
	ffsa_back #(
		.MAX_CELLS (MAX_CELLS),
		.MAX_VARS  (MAX_VARS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.init_done (init_done),
		.result    (result)
	);

endmodule

/* tb/sv/tb_face_flux_scatter_accumulator_top.sv */
module tb_face_flux_scatter_accumulator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ffsa_pkg::*;

	localparam int  PERIOD       = 8;
	localparam int  N_CELLS      = 1024;
	localparam int  VAR_SLOTS    = 8;
	localparam int  CELL_SLOTS   = N_CELLS * VAR_SLOTS;
	// a clear walks the whole RAM one entry per cycle
	localparam int  CLEAR_CYCLES = CELL_SLOTS;
	// tail after the last readout: face updates in flight through queue and back end
	localparam int  TAIL_CYCLES  = 200;
	// receiver hold-off used to back the block up into its input
	localparam int  HOLD_CYCLES  = 400;
	// longest honest quiet stretch is up to four clears queued back to back
	localparam int  QUIET_LIMIT  = 200000;
	localparam int  PHASE_ITEMS  = 50;

	// action code 3 has no meaning; the block must swallow it
	localparam logic [1:0] ACT_SPARE = 2'd3;

	localparam longint ACC_TOP   = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_FLOOR = -ACC_TOP - 1;

	typedef struct {
		logic [1:0]  action;
		logic [9:0]  left_cell;
		logic [9:0]  right_cell;
		logic [2:0]  var_index;
		logic [31:0] flux;
		logic [31:0] area;
		logic [31:0] volume;
	} face_item_t;

	typedef struct {
		logic [2:0]         out_var;
		logic signed [47:0] derivative;
		logic               div_error;
		logic               last;
	} derivative_t;

	// Tracks the accumulator store and the derivatives each readout must produce.
	class residual_tracker;
		longint          cell_acc [CELL_SLOTS];
		logic [NV_W-1:0]  num_vars;
		logic [DOM_W-1:0] domain_cells;
		derivative_t     pending [$];
		int              mismatches;

		function new();
			foreach (cell_acc[i]) cell_acc[i] = 0;
			num_vars     = NUM_VARS_RST;
			domain_cells = DOMAIN_RST;
			mismatches   = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == CFG_NUM_VARS) begin
				num_vars = value[NV_W-1:0];
			end else begin
				domain_cells = value[DOM_W-1:0];
			end
		endfunction

		function int active_vars();
			int n;
			n = num_vars;
			if (n < 1) n = 1;
			if (n > VAR_SLOTS) n = VAR_SLOTS;
			return n;
		endfunction

		function longint saturate(longint v);
			if (v > ACC_TOP) return ACC_TOP;
			if (v < ACC_FLOOR) return ACC_FLOOR;
			return v;
		endfunction

		function int outstanding();
			return pending.size();
		endfunction

		function void absorb_item(face_item_t it);
			logic                neg;
			logic [32:0]         fmag;
			longint unsigned     pmag;
			longint unsigned     amag;
			longint unsigned     quot;
			longint              prod;
			longint              acc;
			longint              val;
			int                  n;
			int                  lslot;
			int                  rslot;
			derivative_t         d;
			n = active_vars();
			case (it.action)
				ACT_CLEAR: begin
					foreach (cell_acc[i]) cell_acc[i] = 0;
				end
				ACT_FACE: begin
					if (it.var_index < n) begin
						neg   = it.flux[31];
						fmag  = neg ? (33'h1_0000_0000 - {1'b0, it.flux}) : {1'b0, it.flux};
						// Q32.32 product rounded half away from zero to Q32.16
						pmag  = (64'(fmag) * 64'(it.area) + 64'h8000) >> 16;
						prod  = neg ? -longint'(pmag) : longint'(pmag);
						lslot = it.left_cell * VAR_SLOTS + it.var_index;
						rslot = it.right_cell * VAR_SLOTS + it.var_index;
						// owner first, then neighbour (matters when both are one cell)
						cell_acc[lslot] = saturate(cell_acc[lslot] + prod);
						cell_acc[rslot] = saturate(cell_acc[rslot] - prod);
					end
				end
				ACT_READ: begin
					for (int j = 0; j < n; j++) begin
						lslot       = it.left_cell * VAR_SLOTS + j;
						acc         = cell_acc[lslot];
						d.div_error = 1'b0;
						if (it.left_cell < domain_cells) begin
							neg  = acc > 0;
							amag = (acc < 0) ? longint'(-acc) : longint'(acc);
							if (it.volume == 0) begin
								d.div_error = 1'b1;
								val = (acc == 0) ? 0 : (neg ? ACC_FLOOR : ACC_TOP);
							end else begin
								quot = (amag << 16) / 64'(it.volume);
								if (neg) begin
									val = (quot >= 64'h8000_0000_0000) ? ACC_FLOOR
										: -longint'(quot);
								end else begin
									val = (quot > 64'h7FFF_FFFF_FFFF) ? ACC_TOP
										: longint'(quot);
								end
							end
							cell_acc[lslot] = val;
						end else begin
							val = acc;
						end
						d.out_var    = 3'(j);
						d.derivative = val[47:0];
						d.last       = (j == n - 1);
						pending.push_back(d);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_readout(derivative_t got);
			derivative_t want;
			if (pending.size() == 0) begin
				$error("unexpected result: out_var %0d derivative %0d", got.out_var,
					got.derivative);
				mismatches++;
			end else begin
				want = pending.pop_front();
				if (got.out_var !== want.out_var) begin
					$error("out_var: expected %0d, actual %0d", want.out_var, got.out_var);
					mismatches++;
				end
				if (got.derivative !== want.derivative) begin
					$error("derivative: expected %0d, actual %0d", want.derivative,
						got.derivative);
					mismatches++;
				end
				if (got.div_error !== want.div_error) begin
					$error("div_error: expected %0b, actual %0b", want.div_error,
						got.div_error);
					mismatches++;
				end
				if (got.last !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, got.last);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ffsa_in_if  item_ch ();
	ffsa_out_if result_ch ();

	residual_tracker sb = new();

	bit steady;            // no idling on either side
	bit hold_results;      // receiver backs off for HOLD_CYCLES, sender streams
	bit clear_outstanding; // a clear went in with no readout after it
	int quiet_cycles;

	always #(PERIOD / 2) clk = ~clk;

	face_flux_scatter_accumulator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Watchdog: ends the run if no transaction moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("RESULT: ERROR");
					$finish;
				end
			end
		end
	end

	// Result side: random ready gaps, one long hold-off on request.
	initial begin
		derivative_t got;
		int          gap;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_results) begin
				result_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_results = 1'b0;
			end else begin
				gap = steady ? 0 : $urandom_range(0, 13);
				if (gap != 0) begin
					result_ch.ready = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			result_ch.ready = 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			got.out_var    = result_ch.out_var;
			got.derivative = result_ch.derivative;
			got.div_error  = result_ch.div_error;
			got.last       = result_ch.last;
			sb.check_readout(got);
		end
	end

	// Offer one transaction after a random gap; valid stays high afterwards so
	// a back-to-back item just swaps payload at the next falling edge.
	task automatic offer_item(input face_item_t it);
		int gap;
		gap = (steady || hold_results) ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		if (gap != 0) begin
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.action     = it.action;
		item_ch.left_cell  = it.left_cell;
		item_ch.right_cell = it.right_cell;
		item_ch.var_index  = it.var_index;
		item_ch.flux       = it.flux;
		item_ch.area       = it.area;
		item_ch.volume     = it.volume;
		item_ch.valid      = 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		sb.absorb_item(it);
		if (it.action == ACT_CLEAR) clear_outstanding = 1'b1;
		else if (it.action == ACT_READ) clear_outstanding = 1'b0;
	endtask

	task automatic send_face(input logic [9:0] lc, input logic [9:0] rc,
		input logic [2:0] v, input logic [31:0] fx, input logic [31:0] ar);
		face_item_t it;
		it = '{ACT_FACE, lc, rc, v, fx, ar, $urandom};
		offer_item(it);
	endtask

	task automatic send_read(input logic [9:0] c, input logic [31:0] vol);
		face_item_t it;
		it = '{ACT_READ, c, 10'($urandom), 3'($urandom), $urandom, $urandom, vol};
		offer_item(it);
	endtask

	task automatic send_op(input logic [1:0] act);
		face_item_t it;
		it = '{act, 10'($urandom), 10'($urandom), 3'($urandom), $urandom, $urandom, $urandom};
		offer_item(it);
	endtask

	// Let every expected readout arrive, then give silent work (faces, a clear)
	// time to finish so the block is idle.
	task automatic drain();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (clear_outstanding ? CLEAR_CYCLES + TAIL_CYCLES : TAIL_CYCLES) @(posedge clk);
		clear_outstanding = 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = value[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_wr_en = 1'b0;
		sb.set_reg(idx, value[CFG_DATA_W-1:0]);
	endtask

	// Random traffic: cells mostly from a small pool so faces pile up on cells
	// that are later read out; some fully random cells and variables.
	task automatic run_phase(input int count);
		face_item_t it;
		int         pick;
		int         slot;
		int         k;
		logic [31:0] w;
		for (k = 0; k < count; k++) begin
			pick = hold_results ? 99 : $urandom_range(0, 99);
			if (pick < 2) it.action = ACT_CLEAR;
			else if (pick < 5) it.action = ACT_SPARE;
			else if (pick < 62) it.action = ACT_FACE;
			else it.action = ACT_READ;

			slot = $urandom_range(0, 9);
			it.left_cell = ($urandom_range(0, 3) == 0) ? 10'($urandom)
				: (slot < 8 ? 10'(slot) : 10'(1014 + slot));
			slot = $urandom_range(0, 9);
			it.right_cell = ($urandom_range(0, 3) == 0) ? 10'($urandom)
				: (slot < 8 ? 10'(slot) : 10'(1014 + slot));
			if ($urandom_range(0, 9) == 0) it.right_cell = it.left_cell;

			it.var_index = ($urandom_range(0, 4) == 0) ? 3'($urandom)
				: 3'($urandom_range(0, sb.active_vars() - 1));

			case ($urandom_range(0, 3))
				0: it.flux = $urandom;
				1: begin
					w = $urandom_range(0, 32'h3_FFFF);
					it.flux = $urandom_range(0, 1) ? -w : w;
				end
				2: begin
					case ($urandom_range(0, 4))
						0: it.flux = 32'h8000_0000;
						1: it.flux = 32'h7FFF_FFFF;
						2: it.flux = 32'h0000_0000;
						3: it.flux = 32'h0000_0001;
						default: it.flux = 32'hFFFF_FFFF;
					endcase
				end
				default: it.flux = $urandom;
			endcase

			case ($urandom_range(0, 2))
				0: it.area = $urandom;
				1: it.area = $urandom_range(0, 32'h2_0000);
				default: begin
					case ($urandom_range(0, 3))
						0: it.area = 32'h0000_0000;
						1: it.area = 32'hFFFF_FFFF;
						2: it.area = 32'h0000_8000;
						default: it.area = 32'h0001_0000;
					endcase
				end
			endcase

			case ($urandom_range(0, 4))
				0: it.volume = 32'h0;
				1, 2: it.volume = $urandom_range(1, 32'h3_0000);
				3: it.volume = $urandom;
				default: it.volume = $urandom_range(0, 1) ? 32'h1 : 32'hFFFF_FFFF;
			endcase

			offer_item(it);
		end
	endtask

	initial begin
		item_ch.valid      = 1'b0;
		item_ch.action     = ACT_CLEAR;
		item_ch.left_cell  = '0;
		item_ch.right_cell = '0;
		item_ch.var_index  = '0;
		item_ch.flux       = '0;
		item_ch.area       = '0;
		item_ch.volume     = '0;
		result_ch.ready    = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_index          = CFG_NUM_VARS;
		cfg_wdata          = '0;
		steady             = 1'b0;
		hold_results       = 1'b0;
		clear_outstanding  = 1'b0;
		quiet_cycles       = 0;
		arst_n             = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part with reset config (5 vars, every cell in the domain).
		// Input stays stalled through the post-reset clearing pass.
		send_face(10'd0, 10'd1, 3'd0, 32'h0001_0000, 32'h0001_0000);
		// largest negative flux times largest area, three times: saturates both cells
		repeat (3) send_face(10'd2, 10'd3, 3'd4, 32'h8000_0000, 32'hFFFF_FFFF);
		// owner and neighbour the same cell: add then subtract
		send_face(10'd5, 10'd5, 3'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		// exact half LSB products: round away from zero both ways
		send_face(10'd6, 10'd7, 3'd2, 32'h0000_0001, 32'h0000_8000);
		send_face(10'd6, 10'd7, 3'd3, 32'hFFFF_FFFF, 32'h0000_8000);
		// variable beyond the active count: no effect
		send_face(10'd0, 10'd1, 3'd5, 32'h1234_5678, 32'h0002_0000);
		send_face(10'd1023, 10'd1022, 3'd3, 32'h0001_2345, 32'h0003_0000);
		send_op(ACT_SPARE);
		send_read(10'd0, 32'h0001_0000);
		send_read(10'd1, 32'h0000_0000);  // zero volume with nonzero accumulator
		send_read(10'd2, 32'h0000_0001);  // tiny volume: quotient saturates
		send_read(10'd3, 32'hFFFF_FFFF);
		send_read(10'd5, 32'h0001_0000);
		send_read(10'd6, 32'h0000_8000);
		send_read(10'd7, 32'h0003_0000);
		send_read(10'd4, 32'h0000_0000);  // zero volume, zero accumulator
		send_read(10'd1023, 32'h0002_0000);
		send_read(10'd2, 32'h0001_0000);  // sees the written-back derivative
		send_op(ACT_CLEAR);
		send_read(10'd1, 32'h0001_0000);
		drain();

		// boundary cells read out raw
		write_reg(CFG_DOMAIN_CELLS, 4);
		send_face(10'd1023, 10'd5, 3'd0, 32'h8000_0000, 32'hFFFF_FFFF);
		send_read(10'd5, 32'h0000_0000);
		send_read(10'd1023, 32'h0001_0000);
		drain();

		// all variables, whole domain; starts with the receiver backed off
		write_reg(CFG_NUM_VARS, 8);
		write_reg(CFG_DOMAIN_CELLS, 1024);
		hold_results = 1'b1;
		run_phase(PHASE_ITEMS);
		drain();

		// one variable, no domain cells at all
		write_reg(CFG_NUM_VARS, 1);
		write_reg(CFG_DOMAIN_CELLS, 0);
		run_phase(PHASE_ITEMS);
		drain();

		// zero variables clamps to one; largest domain setting
		write_reg(CFG_NUM_VARS, 0);
		write_reg(CFG_DOMAIN_CELLS, 2047);
		run_phase(PHASE_ITEMS);
		drain();

		// count above the limit clamps to eight; boundary inside the cell pool
		write_reg(CFG_NUM_VARS, 15);
		write_reg(CFG_DOMAIN_CELLS, 5);
		run_phase(PHASE_ITEMS);
		drain();

		// no idling on either side
		write_reg(CFG_NUM_VARS, 3);
		write_reg(CFG_DOMAIN_CELLS, $urandom_range(0, 1024));
		steady = 1'b1;
		run_phase(PHASE_ITEMS);
		drain();

		if (sb.mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/ffsa_pkg.sv
src/ffsa_if.sv
src/ffsa_front.sv
src/ffsa_queue.sv
src/ffsa_div.sv
src/ffsa_back.sv
src/face_flux_scatter_accumulator_top.sv
tb/sv/tb_face_flux_scatter_accumulator_top.sv
